>>> rtl/spt_pkg.sv
// Shared constants and types for the sorted process table.
// No dependencies; every other file imports this package.
package spt_pkg;

  localparam int CAPACITY = 64;
  localparam int TAG_BITS = 16;
  localparam int PID_W = 22;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ENT_W = PID_W + 8 + 8 + TAG_BITS;

  localparam logic [1:0] FUNC_UPSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;
  localparam logic [1:0] FUNC_JOB    = 2'd3;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND  = 3'd3;
  localparam logic [2:0] ST_PROTECTED = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [PID_W-1:0]    pid;
    logic [7:0]          job;
    logic [7:0]          state;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture the request word, clear the scan index
    logic rd;         // read memory at the scan index
    logic inc;        // advance the scan index
    logic dec;        // step the scan index down
    logic wr_new;     // write the request entry at the scan index
    logic wr_data;    // write the last read entry at the scan index
    logic set_pos;    // latch scan index as result position
    logic keep_row;   // latch last read entry as result row
    logic cnt_inc;
    logic cnt_dec;
    logic seek_top;   // set scan index to count - 1
  } spt_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic at_end;      // scan index equals count
    logic at_pos;      // scan index equals result position
    logic ge_key;      // last read pid >= key
    logic eq_key;      // last read pid == key
    logic eq_job;      // last read job == key job
    logic empty;
    logic full;
    logic is_prot;     // key equals protected pid
    logic [1:0] func;
  } spt_stat_t;

endpackage

>>> rtl/spt_datapath.sv
// Datapath of the sorted process table: entry memory, scan index, count,
// request and result registers. Depends on spt_pkg.
module spt_datapath
  import spt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          in_func,
  input  logic [PID_W-1:0]    in_pid_key,
  input  logic [7:0]          in_job_number,
  input  logic [7:0]          in_state_code,
  input  logic [15:0]         in_command_tag,
  input  logic [PID_W-1:0]    prot_pid,
  input  spt_cmd_t            cmd,
  output spt_stat_t           stat,
  output entry_t              row_q,
  output logic [IDX_W-1:0]    pos_q,
  output logic [CNT_W-1:0]    count_q
);

  entry_t            mem [CAPACITY];
  entry_t            rd_r;
  entry_t            req_r;
  logic [1:0]        func_r;
  logic [CNT_W-1:0]  idx_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  pos_r;
  entry_t            row_r;

  // Entry memory, one port, registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_new) begin
      mem[idx_r[IDX_W-1:0]] <= req_r;
    end else if (cmd.wr_data) begin
      mem[idx_r[IDX_W-1:0]] <= rd_r;
    end
    if (cmd.rd) begin
      rd_r <= mem[idx_r[IDX_W-1:0]];
    end
  end

  // Request word and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      req_r  <= '{pid: in_pid_key, job: in_job_number, state: in_state_code,
                  tag: in_command_tag[TAG_BITS-1:0]};
    end
    if (cmd.set_pos) begin
      pos_r <= idx_r[IDX_W-1:0];
    end
    if (cmd.keep_row) begin
      row_r <= rd_r;
    end
  end

  // Scan index and valid count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.seek_top) begin
        idx_r <= cnt_r - CNT_W'(1);
      end else if (cmd.inc) begin
        idx_r <= idx_r + CNT_W'(1);
      end else if (cmd.dec) begin
        idx_r <= idx_r - CNT_W'(1);
      end
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  assign stat.at_end  = (idx_r == cnt_r);
  assign stat.at_pos  = (idx_r[IDX_W-1:0] == pos_r);
  assign stat.ge_key  = (rd_r.pid >= req_r.pid);
  assign stat.eq_key  = (rd_r.pid == req_r.pid);
  assign stat.eq_job  = (rd_r.job == req_r.job);
  assign stat.empty   = (cnt_r == '0);
  assign stat.full    = (cnt_r == CNT_W'(CAPACITY));
  assign stat.is_prot = (req_r.pid == prot_pid);
  assign stat.func    = func_r;

  assign row_q   = row_r;
  assign pos_q   = pos_r;
  assign count_q = cnt_r;

endmodule

>>> rtl/spt_ctrl.sv
// Controller of the sorted process table: sequences scans and shifts.
// Depends on spt_pkg; drives spt_datapath through spt_cmd_t.
module spt_ctrl
  import spt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  spt_stat_t  stat,
  output spt_cmd_t   cmd,
  output logic       done,
  output logic [2:0] res_status,
  output logic       res_none,
  output logic       res_req
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_WAIT  = 4'd2;
  localparam logic [3:0] S_TEST  = 4'd3;
  localparam logic [3:0] S_DECIDE= 4'd4;
  localparam logic [3:0] S_RMRD  = 4'd5;
  localparam logic [3:0] S_RMWT  = 4'd6;
  localparam logic [3:0] S_RMWR  = 4'd7;
  localparam logic [3:0] S_INRD  = 4'd8;
  localparam logic [3:0] S_INWT  = 4'd9;
  localparam logic [3:0] S_INWR  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;
  localparam logic [3:0] S_INNEW = 4'd12;
  localparam logic [3:0] S_INDEC = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [2:0] status_r, status_nxt;
  logic       none_r, none_nxt;
  logic       req_r, req_nxt;
  logic       hit_r, hit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      status_r <= ST_FOUND;
      none_r <= 1'b1;
      req_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      status_r <= status_nxt;
      none_r <= none_nxt;
      req_r <= req_nxt;
      hit_r <= hit_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    status_nxt = status_r;
    none_nxt = none_r;
    req_nxt = req_r;
    hit_nxt = hit_r;
    done = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          hit_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      // Read the entry at the scan index, or stop at the end.
      S_SCAN: begin
        if (stat.at_end) begin
          cmd.set_pos = 1'b1;
          hit_nxt = 1'b0;
          state_nxt = S_DECIDE;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (stat.func == FUNC_JOB) begin
          if (stat.eq_job) begin
            cmd.set_pos = 1'b1;
            cmd.keep_row = 1'b1;
            hit_nxt = 1'b1;
            state_nxt = S_DECIDE;
          end else begin
            cmd.inc = 1'b1;
            state_nxt = S_SCAN;
          end
        end else if (stat.ge_key) begin
          cmd.set_pos = 1'b1;
          cmd.keep_row = 1'b1;
          hit_nxt = stat.eq_key;
          state_nxt = S_DECIDE;
        end else begin
          cmd.inc = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      // The scan index sits at the lower bound or first job match.
      S_DECIDE: begin
        none_nxt = 1'b0;
        req_nxt = 1'b0;
        case (stat.func)
          FUNC_JOB, FUNC_LOOKUP: begin
            status_nxt = hit_r ? ST_FOUND : ST_NOTFOUND;
            none_nxt = !hit_r;
            state_nxt = S_DONE;
          end
          FUNC_REMOVE: begin
            if (!hit_r) begin
              status_nxt = ST_NOTFOUND;
              none_nxt = 1'b1;
              state_nxt = S_DONE;
            end else begin
              status_nxt = ST_REMOVED;
              cmd.inc = 1'b1;
              state_nxt = S_RMRD;
            end
          end
          default: begin
            if (!stat.empty && stat.is_prot) begin
              status_nxt = ST_PROTECTED;
              none_nxt = 1'b1;
              state_nxt = S_DONE;
            end else if (hit_r) begin
              status_nxt = ST_FOUND;
              req_nxt = 1'b1;
              state_nxt = S_INNEW;
            end else if (stat.full) begin
              status_nxt = ST_FULL;
              none_nxt = 1'b1;
              state_nxt = S_DONE;
            end else if (stat.at_end) begin
              // Appending after the last entry needs no shift.
              status_nxt = ST_INSERTED;
              req_nxt = 1'b1;
              state_nxt = S_INNEW;
            end else begin
              status_nxt = ST_INSERTED;
              req_nxt = 1'b1;
              cmd.seek_top = 1'b1;
              state_nxt = S_INRD;
            end
          end
        endcase
      end
      // Remove: move entry idx down to idx-1 until the end.
      S_RMRD: begin
        if (stat.at_end) begin
          cmd.cnt_dec = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_RMWT;
        end
      end
      S_RMWT: begin
        cmd.dec = 1'b1;
        state_nxt = S_RMWR;
      end
      S_RMWR: begin
        cmd.wr_data = 1'b1;
        cmd.inc = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        cmd.inc = 1'b1;
        state_nxt = S_RMRD;
      end
      // Insert: move entries up from the top down to the position.
      S_INRD: begin
        cmd.rd = 1'b1;
        state_nxt = S_INWT;
      end
      S_INWT: begin
        cmd.inc = 1'b1;
        state_nxt = S_INWR;
      end
      S_INWR: begin
        cmd.wr_data = 1'b1;
        cmd.dec = 1'b1;
        state_nxt = S_INDEC;
      end
      // Stop once the entry at the position has moved up, else step down.
      S_INDEC: begin
        if (stat.at_pos) begin
          state_nxt = S_INNEW;
        end else begin
          cmd.dec = 1'b1;
          state_nxt = S_INRD;
        end
      end
      S_INNEW: begin
        if (stat.at_pos) begin
          cmd.wr_new = 1'b1;
          if (status_r == ST_INSERTED) begin
            cmd.cnt_inc = 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          cmd.dec = 1'b1;
        end
      end
      S_DONE: begin
        done = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign res_status = status_r;
  assign res_none = none_r;
  assign res_req = req_r;

endmodule

>>> rtl/sorted_process_table_core.sv
// Top level of the sorted process table: controller, datapath, result ports.
// Depends on spt_pkg, spt_ctrl and spt_datapath.
//
// A command is taken when start is high and busy is low; busy stays high
// until its result has been shown. Each result appears for one cycle with
// out_valid and cannot be held off by the receiver. A command scans entries
// up to the key or job match, and an insert or remove then moves entries
// one by one, all through the single port of the entry memory.
module sorted_process_table_core
  import spt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_func,
  input  logic [PID_W-1:0]  in_pid_key,
  input  logic [7:0]        in_job_number,
  input  logic [7:0]        in_state_code,
  input  logic [15:0]       in_command_tag,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [PID_W-1:0]  cfg_data,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [PID_W-1:0]  out_found_pid,
  output logic [7:0]        out_found_job,
  output logic [7:0]        out_found_state,
  output logic [15:0]       out_found_tag,
  output logic [5:0]        out_position,
  output logic [6:0]        out_entry_count
);

  spt_cmd_t         cmd;
  spt_stat_t        stat;
  entry_t           row_q;
  logic [IDX_W-1:0] pos_q;
  logic [CNT_W-1:0] count_q;
  logic             done;
  logic [2:0]       res_status;
  logic             res_none;
  logic             res_req;
  logic [PID_W-1:0] prot_r;
  entry_t           shown;

  // Protected key register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prot_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      prot_r <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  spt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .stat(stat),
    .cmd(cmd), .done(done), .res_status(res_status),
    .res_none(res_none), .res_req(res_req)
  );

  spt_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_func(in_func), .in_pid_key(in_pid_key),
    .in_job_number(in_job_number), .in_state_code(in_state_code),
    .in_command_tag(in_command_tag), .prot_pid(prot_r), .cmd(cmd),
    .stat(stat), .row_q(row_q), .pos_q(pos_q), .count_q(count_q)
  );

  // Request word for upsert results, captured alongside the datapath copy.
  entry_t req_cap_r;
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_cap_r <= '{pid: in_pid_key, job: in_job_number, state: in_state_code,
                     tag: in_command_tag[TAG_BITS-1:0]};
    end
  end

  assign shown = res_req ? req_cap_r : row_q;

  // Result word.
  assign out_valid       = done;
  assign out_status      = res_status;
  assign out_found_pid   = res_none ? '0 : shown.pid;
  assign out_found_job   = res_none ? '0 : shown.job;
  assign out_found_state = res_none ? '0 : shown.state;
  assign out_found_tag   = res_none ? '0 : 16'(shown.tag);
  assign out_position    = res_none ? '0 : 6'(pos_q);
  assign out_entry_count = 7'(count_q);

  // The count never exceeds capacity.
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    count_q <= CNT_W'(CAPACITY)) else $error("count above capacity");
  // A result only appears while a command is in flight.
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> busy) else $error("result while idle");
  // Busy drops right after a result.
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !busy) else $error("busy after result");

endmodule
